>>> hdl/ahrc_pkg.sv
// Package: shared types, constants and step table for the hold-repeat counter.
`timescale 1ns / 1ps

package ahrc_pkg;

  localparam int unsigned REPEAT_MS   = 500;
  localparam int unsigned ACCEL_MS    = 3000;
  localparam int unsigned STEP_LEVELS = 6;

  localparam int unsigned TIME_W   = 31;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MAXIDX_W = 3;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned AMT_W    = 8;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic REG_START_VALUE = 1'b0;
  localparam logic REG_MAX_STEP    = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              up_press;
    logic              down_press;
    logic              up_release;
    logic              down_release;
  } item_t;

  typedef struct packed {
    logic                      holding;
    logic                      direction_up;
    logic [TIME_W-1:0]         hold_start_time;
    logic [TIME_W-1:0]         next_repeat_time;
    logic signed [VALUE_W-1:0] current_value;
  } state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] edited_value;
    logic                      value_changed;
    logic                      hold_active;
  } result_t;

  function automatic logic [AMT_W-1:0] step_amount(input logic [IDX_W-1:0] idx);
    logic [AMT_W-1:0] amt;
    case (idx)
      4'd0:    amt = 8'd1;
      4'd1:    amt = 8'd5;
      4'd2:    amt = 8'd10;
      4'd3:    amt = 8'd25;
      4'd4:    amt = 8'd100;
      default: amt = 8'd200;
    endcase
    return amt;
  endfunction

endpackage

>>> hdl/ahrc_step.sv
// Step logic: next hold state and result for one update transaction.
`timescale 1ns / 1ps

module ahrc_step (
  input  ahrc_pkg::state_t                    st_cur,
  input  ahrc_pkg::item_t                     item,
  input  logic [ahrc_pkg::MAXIDX_W-1:0]       max_step_index,
  output ahrc_pkg::state_t                    st_nxt,
  output ahrc_pkg::result_t                   res
);

  localparam logic [ahrc_pkg::TIME_W-1:0] RepeatT = ahrc_pkg::TIME_W'(ahrc_pkg::REPEAT_MS);
  localparam logic [ahrc_pkg::IDX_W-1:0]  LastIdx =
    ahrc_pkg::IDX_W'(ahrc_pkg::STEP_LEVELS - 1);

  logic                             press;
  logic                             release_ev;
  logic                             hold;
  logic                             dir_up;
  logic [ahrc_pkg::TIME_W-1:0]      h_start;
  logic [ahrc_pkg::TIME_W-1:0]      nrt;
  logic [ahrc_pkg::TIME_W-1:0]      first_tick;
  logic [ahrc_pkg::TIME_W-1:0]      elapsed;
  logic [ahrc_pkg::IDX_W-1:0]       level;
  logic [ahrc_pkg::IDX_W-1:0]       cap;
  logic [ahrc_pkg::IDX_W-1:0]       idx;
  logic                             do_step;
  logic                             do_repeat;
  logic [ahrc_pkg::AMT_W-1:0]       amount;
  logic signed [ahrc_pkg::VALUE_W:0] ext_val;
  logic signed [ahrc_pkg::VALUE_W:0] ext_amt;
  logic signed [ahrc_pkg::VALUE_W:0] sum;
  logic signed [ahrc_pkg::VALUE_W-1:0] sat_val;

  assign press      = item.up_press | item.down_press;
  assign release_ev = item.up_release | item.down_release;
  assign hold       = press | st_cur.holding;
  assign dir_up     = press ? item.up_press : st_cur.direction_up;
  assign h_start    = press ? item.now_ms : st_cur.hold_start_time;
  assign nrt        = press ? (item.now_ms + RepeatT) : st_cur.next_repeat_time;
  assign first_tick = h_start + RepeatT;
  assign elapsed    = item.now_ms - h_start;

  // acceleration level: count of crossed multiples of the accel period
  always_comb begin
    level = '0;
    for (int k = 1; k < int'(ahrc_pkg::STEP_LEVELS); k++) begin
      if (elapsed >= ahrc_pkg::TIME_W'(k * ahrc_pkg::ACCEL_MS)) begin
        level = level + ahrc_pkg::IDX_W'(1);
      end
    end
  end

  assign cap = (ahrc_pkg::IDX_W'(max_step_index) > LastIdx) ? LastIdx
                                                           : ahrc_pkg::IDX_W'(max_step_index);
  assign idx = (level > cap) ? cap : level;

  assign do_repeat = hold & ~release_ev & (item.now_ms >= nrt);
  assign do_step   = hold & ((release_ev & (nrt == first_tick)) | do_repeat);
  assign amount    = do_repeat ? ahrc_pkg::step_amount(idx) : ahrc_pkg::AMT_W'(1);

  assign ext_val = {st_cur.current_value[ahrc_pkg::VALUE_W-1], st_cur.current_value};
  assign ext_amt = $signed({{(ahrc_pkg::VALUE_W + 1 - ahrc_pkg::AMT_W){1'b0}}, amount});
  assign sum     = dir_up ? (ext_val + ext_amt) : (ext_val - ext_amt);

  always_comb begin
    if (sum[ahrc_pkg::VALUE_W] != sum[ahrc_pkg::VALUE_W-1]) begin
      sat_val = sum[ahrc_pkg::VALUE_W] ? {1'b1, {(ahrc_pkg::VALUE_W-1){1'b0}}}
                                       : {1'b0, {(ahrc_pkg::VALUE_W-1){1'b1}}};
    end else begin
      sat_val = sum[ahrc_pkg::VALUE_W-1:0];
    end
  end

  always_comb begin
    st_nxt.holding          = hold & ~release_ev;
    st_nxt.direction_up     = dir_up;
    st_nxt.hold_start_time  = h_start;
    st_nxt.next_repeat_time = do_repeat ? (nrt + RepeatT) : nrt;
    st_nxt.current_value    = do_step ? sat_val : st_cur.current_value;
    res.edited_value        = st_nxt.current_value;
    res.value_changed       = do_step;
    res.hold_active         = st_nxt.holding;
  end

endmodule

>>> hdl/accelerating_hold_repeat_counter.sv
// Top level: accelerating auto-repeat value editor with stream and APB ports.
//
// Each input transaction on in_* is one button update: a millisecond time
// stamp and the up/down press and release events. Every input transaction
// yields exactly one output transaction on out_* carrying the edited value,
// a flag that this update stepped the value, and the hold flag.
// Each result passes through the input register, then the result register.
// Throughput: one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transaction and
// one more item can wait in the input register; in_tready drops only when
// both are full.
// Registers (APB, 32 bit): 0x0 start_value (write also loads the edited
// value), 0x4 max_step_index. Write only while no transaction is in flight.
// Reset (rst_n low, synchronous) empties both registers, ends any hold and
// sets the value and both configuration registers to zero.
`timescale 1ns / 1ps

module accelerating_hold_repeat_counter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [30:0] now_ms, [31] up_press, [32] down_press, [33] up_release,
  // [34] down_release, [39:35] ignored
  input  logic [ahrc_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] edited_value, [32] value_changed, [33] hold_active, [39:34] zero
  output logic [ahrc_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ahrc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [ahrc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [ahrc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  logic                                 s1_v_r;
  ahrc_pkg::item_t                      s1_item_r;
  logic                                 out_v_r;
  ahrc_pkg::result_t                    out_res_r;
  ahrc_pkg::state_t                     st_r;
  ahrc_pkg::state_t                     st_nxt;
  ahrc_pkg::state_t                     st_step;
  ahrc_pkg::result_t                    res_step;
  logic signed [ahrc_pkg::VALUE_W-1:0]  start_value_r;
  logic [ahrc_pkg::MAXIDX_W-1:0]        max_idx_r;
  logic                                 in_acc;
  logic                                 s1_adv;
  logic                                 cfg_wr;
  logic                                 cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_paddr[2];

  assign s1_adv    = s1_v_r & (~out_v_r | out_tready);
  assign in_tready = ~s1_v_r | s1_adv;
  assign in_acc    = in_tvalid & in_tready;

  ahrc_step u_step (
    .st_cur         (st_r),
    .item           (s1_item_r),
    .max_step_index (max_idx_r),
    .st_nxt         (st_step),
    .res            (res_step)
  );

  always_comb begin
    st_nxt = st_r;
    if (s1_adv) begin
      st_nxt = st_step;
    end
    if (cfg_wr && cfg_sel == ahrc_pkg::REG_START_VALUE) begin
      st_nxt.current_value = $signed(cfg_pwdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      st_r          <= '0;
      start_value_r <= '0;
      max_idx_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_sel)
          ahrc_pkg::REG_START_VALUE: start_value_r <= $signed(cfg_pwdata);
          ahrc_pkg::REG_MAX_STEP:    max_idx_r     <= cfg_pwdata[ahrc_pkg::MAXIDX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.now_ms       <= in_tdata[ahrc_pkg::TIME_W-1:0];
      s1_item_r.up_press     <= in_tdata[ahrc_pkg::TIME_W];
      s1_item_r.down_press   <= in_tdata[ahrc_pkg::TIME_W+1];
      s1_item_r.up_release   <= in_tdata[ahrc_pkg::TIME_W+2];
      s1_item_r.down_release <= in_tdata[ahrc_pkg::TIME_W+3];
    end
    if (s1_adv) begin
      out_res_r <= res_step;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(ahrc_pkg::OUT_DATA_W - ahrc_pkg::VALUE_W - 2){1'b0}},
                       out_res_r.hold_active, out_res_r.value_changed,
                       out_res_r.edited_value};

  always_comb begin
    case (cfg_sel)
      ahrc_pkg::REG_START_VALUE: cfg_prdata = start_value_r;
      ahrc_pkg::REG_MAX_STEP:
        cfg_prdata = {{(ahrc_pkg::CFG_DATA_W - ahrc_pkg::MAXIDX_W){1'b0}}, max_idx_r};
      default:                   cfg_prdata = '0;
    endcase
  end

endmodule

>>> hdl/ahrc_checker.sv
// Checker: port-level assertions for the hold-repeat counter, bound to the top level.
`timescale 1ns / 1ps

module ahrc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ahrc_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a ready receiver never backs up the input
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while receiver ready");

  // accepted transaction reaches the output via the input and result registers once the receiver is ready
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("result missing after input transaction");

endmodule

bind accelerating_hold_repeat_counter ahrc_checker u_ahrc_checker (.*);
